FILE: hw/rtl/dis_pkg.sv
// Shared types and constants for the descending insertion sorter.
package dis_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SCORE_W  = 32;
  localparam int COORD_W  = 5;
  localparam int DATA_W   = 48;
  localparam int PAD_W    = DATA_W - SCORE_W - 2 * COORD_W;

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

FILE: hw/rtl/dis_cell.sv
// One cell of the sorting chain: holds one entry and trades it with its neighbors.
module dis_cell (
  input  logic            clk,
  input  logic            rst,
  input  dis_pkg::ctl_t   ctl,
  input  dis_pkg::entry_t new_entry,
  input  dis_pkg::entry_t prev_entry,
  input  logic            prev_keep,
  input  dis_pkg::entry_t next_entry,
  output dis_pkg::entry_t cur,
  output logic            keep
);

  dis_pkg::entry_t cur_next;

  assign keep = cur.valid && (cur.score >= new_entry.score);

  always_comb begin
    cur_next = cur;
    if (ctl.insert) begin
      if (keep) begin
        cur_next = cur;
      end else if (prev_keep) begin
        cur_next       = new_entry;
        cur_next.valid = 1'b1;
      end else begin
        cur_next = prev_entry;
      end
    end else if (ctl.drain) begin
      cur_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
    cur.score <= cur_next.score;
    cur.x     <= cur_next.x;
    cur.y     <= cur_next.y;
  end

endmodule

FILE: hw/rtl/dis_chain.sv
// Row of sorting cells, highest score at the head.
module dis_chain (
  input  logic            clk,
  input  logic            rst,
  input  dis_pkg::ctl_t   ctl,
  input  dis_pkg::entry_t new_entry,
  output dis_pkg::entry_t head
);

  dis_pkg::entry_t cells [dis_pkg::CAPACITY];
  logic            keeps [dis_pkg::CAPACITY];

  for (genvar i = 0; i < dis_pkg::CAPACITY; i++) begin : g_cell
    dis_pkg::entry_t prev_e;
    dis_pkg::entry_t next_e;
    logic            prev_k;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_e = cells[i-1];
      assign prev_k = keeps[i-1];
    end

    if (i == dis_pkg::CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cells[i+1];
    end

    dis_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_keep  (prev_k),
      .next_entry (next_e),
      .cur        (cells[i]),
      .keep       (keeps[i])
    );
  end

  assign head = cells[0];

endmodule

FILE: hw/rtl/descending_insertion_sorter_core.sv
// Top level of the descending insertion sorter with its load and drain control.
//
// Items enter on the s_axis channel, one per cycle while s_axis_tready is high.
// Each item is placed into a row of 64 cells kept in descending score order;
// items with equal scores keep their arrival order. Items that arrive while
// the row is full are dropped and mark the set as overflowed.
// The item with s_axis_tlast high closes the set. From the next cycle the
// stored items leave on the m_axis channel, highest score first, one per cycle
// while m_axis_tready is high. The final result carries m_axis_tlast, and
// every result of an overflowed set carries m_axis_tuser high.
// The input is held off during the drain because the cell row is shifting
// toward the head.
// The head cell is the output register: a stall on m_axis_tready freezes the
// row and holds the result steady.
// Reset empties the row and clears the count and the overflow mark; the
// block can take an item in the first cycle after reset.
module descending_insertion_sorter_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [dis_pkg::DATA_W-1:0] s_axis_tdata,  // score, pos_x, pos_y, zero pad
  input  logic                       s_axis_tlast,  // last_item
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [dis_pkg::DATA_W-1:0] m_axis_tdata,  // sorted_score, sorted_x, sorted_y, zero pad
  output logic                       m_axis_tlast,  // last_result
  output logic                       m_axis_tuser   // overflow
);

  dis_pkg::state_t state;
  dis_pkg::state_t state_next;
  logic [dis_pkg::CNT_W-1:0] count;
  logic [dis_pkg::CNT_W-1:0] count_next;
  logic overflow;
  logic overflow_next;

  dis_pkg::ctl_t   ctl;
  dis_pkg::entry_t new_entry;
  dis_pkg::entry_t head;

  logic in_fire;
  logic out_fire;
  logic full;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign full     = (count == dis_pkg::CNT_W'(dis_pkg::CAPACITY));

  assign new_entry.valid = 1'b1;
  assign new_entry.score = s_axis_tdata[dis_pkg::SCORE_W-1:0];
  assign new_entry.x     = s_axis_tdata[dis_pkg::SCORE_W +: dis_pkg::COORD_W];
  assign new_entry.y     = s_axis_tdata[dis_pkg::SCORE_W + dis_pkg::COORD_W +: dis_pkg::COORD_W];

  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    unique case (state)
      dis_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            overflow_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
          if (s_axis_tlast) begin
            state_next = dis_pkg::ST_DRAIN;
          end
        end
      end
      dis_pkg::ST_DRAIN: begin
        if (out_fire) begin
          count_next = count - 1'b1;
          if (count == dis_pkg::CNT_W'(1)) begin
            state_next    = dis_pkg::ST_LOAD;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = dis_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    ctl           = '0;
    unique case (state)
      dis_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        ctl.insert    = s_axis_tvalid && !full;
      end
      dis_pkg::ST_DRAIN: begin
        m_axis_tvalid = 1'b1;
        ctl.drain     = m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dis_pkg::ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  dis_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .new_entry (new_entry),
    .head      (head)
  );

  assign m_axis_tdata = {{dis_pkg::PAD_W{1'b0}}, head.y, head.x, head.score};
  assign m_axis_tlast = (count == dis_pkg::CNT_W'(1)) && head.valid;
  assign m_axis_tuser = overflow;

endmodule

FILE: hw/rtl/dis_checker.sv
// Port-level checks for the descending insertion sorter and their binding.
module dis_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tlast,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [dis_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic                       m_axis_tuser
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("Input taken while results are pending.");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("Closing item did not start the result stream.");

  a_end_of_set: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("Final result did not return the block to loading.");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("Stalled result changed.");

endmodule

bind descending_insertion_sorter_core dis_checker u_dis_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the descending insertion sorter core.
module testbench;
  import dis_pkg::*;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
  } cand_t;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic                      last;
    logic                      ovf;
  } ranked_t;

  class sorted_set_board;
    cand_t   ranked[$];
    bit      dropped;
    ranked_t expected_ranked[$];
    int      errors;

    function new();
      dropped = 0;
      errors  = 0;
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function void note_candidate(cand_t c, bit last);
      int pos;
      ranked_t r;
      pos = 0;
      if (ranked.size() < CAPACITY) begin
        while (pos < ranked.size() && ranked[pos].score >= c.score) pos++;
        ranked.insert(pos, c);
      end else begin
        dropped = 1;
      end
      if (last) begin
        foreach (ranked[i]) begin
          r.score = ranked[i].score;
          r.x     = ranked[i].x;
          r.y     = ranked[i].y;
          r.last  = (i == ranked.size() - 1);
          r.ovf   = dropped;
          expected_ranked.push_back(r);
        end
        ranked.delete();
        dropped = 0;
      end
    endfunction

    task check_ranked(logic [DATA_W-1:0] data, logic last, logic ovf);
      ranked_t e;
      logic signed [SCORE_W-1:0] sc;
      logic [COORD_W-1:0] px, py;
      sc = data[SCORE_W-1:0];
      px = data[SCORE_W +: COORD_W];
      py = data[SCORE_W+COORD_W +: COORD_W];
      if (expected_ranked.size() == 0) begin
        flag_mismatch($sformatf("unexpected result score %0d", sc));
      end else begin
        e = expected_ranked.pop_front();
        if (sc !== e.score)
          flag_mismatch($sformatf("score %0d, expected %0d", sc, e.score));
        if (px !== e.x) flag_mismatch($sformatf("x %0d, expected %0d", px, e.x));
        if (py !== e.y) flag_mismatch($sformatf("y %0d, expected %0d", py, e.y));
        if (last !== e.last)
          flag_mismatch($sformatf("last %b, expected %b", last, e.last));
        if (ovf !== e.ovf)
          flag_mismatch($sformatf("overflow %b, expected %b", ovf, e.ovf));
      end
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;

  sorted_set_board board = new();
  bit long_hold_request;
  bit recv_enable;
  bit send_no_gaps;

  descending_insertion_sorter_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_ranked(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task send_candidate(logic signed [SCORE_W-1:0] sc, logic [COORD_W-1:0] px,
                      logic [COORD_W-1:0] py, bit last);
    int gap;
    cand_t c;
    gap = send_no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata  = {{PAD_W{1'b0}}, py, px, sc};
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    c.score = sc;
    c.x     = px;
    c.y     = py;
    board.note_candidate(c, last);
    @(negedge clk);
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
      5, 6:    return $signed($urandom_range(0, 3) * 1000) - 1500;
      default: return $urandom;
    endcase
  endfunction

  task send_random_set(int count);
    for (int i = 0; i < count; i++)
      send_candidate(pick_score(), COORD_W'($urandom_range(0, 31)),
                     COORD_W'($urandom_range(0, 31)), i == count - 1);
  endtask

  task wait_drained();
    while (board.expected_ranked.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, bursts without stalls, and one long hold-off.
  initial begin
    int wait_cycles;
    int taken;
    bit burst;
    bit hold_done;
    m_axis_tready = 0;
    taken = 0;
    burst = 0;
    hold_done = 0;
    wait (recv_enable);
    @(negedge clk);
    forever begin
      if (taken % 16 == 0) burst = ($urandom_range(0, 2) == 0);
      if (long_hold_request && !hold_done) begin
        hold_done = 1;
        m_axis_tready = 0;
        repeat (400) @(negedge clk);
      end else begin
        wait_cycles = burst ? 0 : $urandom_range(0, 11);
        if (wait_cycles > 0) begin
          m_axis_tready = 0;
          repeat (wait_cycles) @(negedge clk);
        end
      end
      m_axis_tready = 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int sent;
    int set_idx;
    int size;
    s_axis_tvalid     = 0;
    s_axis_tdata      = '0;
    s_axis_tlast      = 0;
    long_hold_request = 0;
    recv_enable       = 0;
    send_no_gaps      = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    recv_enable = 1;

    // Single-item set.
    send_candidate(32'sd0, 5'd0, 5'd0, 1);
    // Score extremes, coordinate extremes and ties that must stay in order.
    send_no_gaps = 1;
    send_candidate(32'sh8000_0000, 5'd31, 5'd0,  0);
    send_candidate(32'sh7FFF_FFFF, 5'd0,  5'd31, 0);
    send_candidate(-32'sd1,        5'd1,  5'd1,  0);
    send_candidate(32'sd1,         5'd2,  5'd2,  0);
    send_candidate(32'sd5,         5'd3,  5'd3,  0);
    send_candidate(32'sd5,         5'd4,  5'd4,  0);
    send_candidate(32'sh7FFF_FFFF, 5'd5,  5'd5,  0);
    send_candidate(32'sh8000_0000, 5'd6,  5'd6,  0);
    send_candidate(32'sd5,         5'd7,  5'd7,  0);
    send_candidate(32'sd0,         5'd31, 5'd31, 1);
    send_no_gaps = 0;
    // Descending input and ascending input.
    for (int i = 0; i < 4; i++)
      send_candidate(32'sd100 - i, COORD_W'(i), COORD_W'(31 - i), i == 3);
    for (int i = 0; i < 4; i++)
      send_candidate(-32'sd100 + i, COORD_W'(31 - i), COORD_W'(i), i == 3);
    // All scores equal.
    for (int i = 0; i < 3; i++)
      send_candidate(-32'sd7, COORD_W'(i), COORD_W'(i), i == 2);

    sent = 0;
    set_idx = 0;
    while (sent < 180 || set_idx < 6) begin
      send_no_gaps = ($urandom_range(0, 2) == 0);
      case (set_idx)
        2: begin
          size = CAPACITY;
          send_no_gaps = 1;
        end
        3: begin
          size = $urandom_range(3, 8);
          send_no_gaps = 1;
          long_hold_request = 1;
        end
        4:  size = CAPACITY + 2;
        default: size = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30)
                                                    : $urandom_range(1, 10);
      endcase
      if (set_idx == 5) wait_drained();
      send_random_set(size);
      sent += size;
      set_idx++;
    end

    s_axis_tvalid = 0;
    s_axis_tlast  = 0;
    wait_drained();
    repeat (40) @(negedge clk);
    if (board.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dis_pkg.sv
hw/rtl/dis_cell.sv
hw/rtl/dis_chain.sv
hw/rtl/descending_insertion_sorter_core.sv
hw/rtl/dis_checker.sv
dv/testbench.sv
